// File: rtl/skpt_pkg.sv
// ----------------------------------------------------------------------------
// skpt_pkg
// shared types and constants of the sorted key page table
// ----------------------------------------------------------------------------
package skpt_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int KEY_W    = 64;
  localparam int PAGE_W   = 32;
  localparam int OCC_W    = 7;
  localparam int REQ_W    = 2;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [PAGE_W-1:0] page_t;
  typedef logic [OCC_W-1:0]  occ_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_RANGE  = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_RRD,
    ST_RCMP,
    ST_SH_RD,
    ST_SH_WR,
    ST_PUT,
    ST_RESP
  } state_t;

  // one write port, one registered read port
  typedef struct packed {
    logic  we;
    addr_t waddr;
    key_t  wkey;
    page_t wpage;
    logic  re;
    addr_t raddr;
  } mem_ctrl_t;

endpackage

// File: rtl/skpt_if.sv
// ----------------------------------------------------------------------------
// skpt channel interfaces
// request, result and configuration channels with valid and ready
// ----------------------------------------------------------------------------
interface skpt_req_if import skpt_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  key_t             key;
  key_t             key_high;
  page_t            page_number;

  modport source (output valid, req_type, key, key_high, page_number, input ready);
  modport sink   (input valid, req_type, key, key_high, page_number, output ready);
endinterface

interface skpt_rsp_if import skpt_pkg::*;
();
  logic  valid;
  logic  ready;
  logic  hit;
  page_t result_page;
  logic  last;
  occ_t  occupancy;

  modport source (output valid, hit, result_page, last, occupancy, input ready);
  modport sink   (input valid, hit, result_page, last, occupancy, output ready);
endinterface

interface skpt_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: rtl/skpt_store.sv
// ----------------------------------------------------------------------------
// skpt_store
// entry memory: key and page number per slot, registered read
// ----------------------------------------------------------------------------
module skpt_store import skpt_pkg::*;
(
  input  logic      clk,
  input  mem_ctrl_t ctrl,
  output key_t      rkey,
  output page_t     rpage
);

  key_t  key_mem  [CAPACITY];
  page_t page_mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (ctrl.we) begin
      key_mem[ctrl.waddr]  <= ctrl.wkey;
      page_mem[ctrl.waddr] <= ctrl.wpage;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.re) begin
      rkey  <= key_mem[ctrl.raddr];
      rpage <= page_mem[ctrl.raddr];
    end
  end

endmodule

// File: rtl/skpt_cmp.sv
// ----------------------------------------------------------------------------
// skpt_cmp
// shared key comparator: less-than and equal on unsigned keys
// ----------------------------------------------------------------------------
module skpt_cmp import skpt_pkg::*;
(
  input  key_t a,
  input  key_t b,
  output logic lt,
  output logic eq
);

  assign lt = (a < b);
  assign eq = (a == b);

endmodule

// File: rtl/skpt_seq.sv
// ----------------------------------------------------------------------------
// skpt_seq
// request sequencer: scans and shifts entries through the shared comparator
// ----------------------------------------------------------------------------
module skpt_seq import skpt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             is_leaf,
  skpt_req_if.sink         in_ch,
  skpt_rsp_if.source       out_ch,
  output mem_ctrl_t        mem,
  input  key_t             rkey,
  input  page_t            rpage,
  output key_t             cmp_b,
  input  logic             cmp_lt,
  input  logic             cmp_eq
);

  state_t state_r, state_nxt;
  req_t   op_r, op_nxt;
  key_t   key_r, key_nxt;
  key_t   khi_r, khi_nxt;
  page_t  pg_r, pg_nxt;
  addr_t  idx_r, idx_nxt;
  occ_t   cnt_r, cnt_nxt;
  page_t  prev_r, prev_nxt;
  logic   pend_r, pend_nxt;
  page_t  pend_page_r, pend_page_nxt;
  logic   resp_hit_r, resp_hit_nxt;
  page_t  resp_page_r, resp_page_nxt;

  logic   out_valid_r;
  logic   out_hit_r;
  page_t  out_page_r;
  logic   out_last_r;
  occ_t   out_occ_r;

  logic   emit;
  logic   emit_hit;
  page_t  emit_page;
  logic   emit_last;

  logic   accept;
  logic   out_free;
  logic   empty;
  logic   full;
  addr_t  last_idx;
  logic   at_last;
  logic   le;
  req_t   in_op;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r >= OCC_W'(CAPACITY));
  assign last_idx = ADDR_W'(cnt_r - OCC_W'(1));
  assign at_last  = (idx_r == last_idx);
  assign le       = cmp_lt || cmp_eq;
  assign in_op    = req_t'(in_ch.req_type);
  assign cmp_b    = (state_r == ST_RCMP) ? khi_r : key_r;

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.hit         = out_hit_r;
  assign out_ch.result_page = out_page_r;
  assign out_ch.last        = out_last_r;
  assign out_ch.occupancy   = out_occ_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_op)
            REQ_LOOKUP: state_nxt = empty ? ST_RESP : ST_RD;
            REQ_INSERT: state_nxt = full ? ST_RESP : (empty ? ST_PUT : ST_RD);
            REQ_REMOVE: state_nxt = empty ? ST_RESP : ST_RD;
            default:    state_nxt = (!is_leaf || empty) ? ST_RESP : ST_RD;
          endcase
        end
      end
      ST_RD:  state_nxt = ST_CMP;
      ST_CMP: begin
        case (op_r)
          REQ_LOOKUP: state_nxt = (cmp_lt && !at_last) ? ST_RD : ST_RESP;
          REQ_INSERT: begin
            if (cmp_lt)               state_nxt = ST_RESP;
            else if (idx_r == '0)     state_nxt = ST_PUT;
            else                      state_nxt = ST_RD;
          end
          REQ_REMOVE: begin
            if (cmp_lt)               state_nxt = at_last ? ST_RESP : ST_RD;
            else if (cmp_eq && !at_last) state_nxt = ST_SH_RD;
            else                      state_nxt = ST_RESP;
          end
          default: begin
            if (cmp_lt)               state_nxt = at_last ? ST_RESP : ST_RD;
            else                      state_nxt = ST_RCMP;
          end
        endcase
      end
      ST_RRD:  state_nxt = ST_RCMP;
      ST_RCMP: begin
        if (!le)                      state_nxt = ST_RESP;
        else if (pend_r && !out_free) state_nxt = ST_RCMP;
        else                          state_nxt = at_last ? ST_RESP : ST_RRD;
      end
      ST_SH_RD: state_nxt = ST_SH_WR;
      ST_SH_WR: state_nxt = (ADDR_W'(idx_r + 1'b1) == last_idx) ? ST_RESP : ST_SH_RD;
      ST_PUT:   state_nxt = ST_RESP;
      ST_RESP:  state_nxt = out_free ? ST_IDLE : ST_RESP;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    op_nxt        = op_r;
    key_nxt       = key_r;
    khi_nxt       = khi_r;
    pg_nxt        = pg_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    prev_nxt      = prev_r;
    pend_nxt      = pend_r;
    pend_page_nxt = pend_page_r;
    resp_hit_nxt  = resp_hit_r;
    resp_page_nxt = resp_page_r;
    mem           = '0;
    emit          = 1'b0;
    emit_hit      = 1'b0;
    emit_page     = '0;
    emit_last     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt        = in_op;
          key_nxt       = in_ch.key;
          khi_nxt       = in_ch.key_high;
          pg_nxt        = in_ch.page_number;
          idx_nxt       = (in_op == REQ_INSERT && !empty) ? last_idx : '0;
          pend_nxt      = 1'b0;
          resp_hit_nxt  = 1'b0;
          resp_page_nxt = '0;
        end
      end
      ST_RD, ST_RRD: begin
        mem.re    = 1'b1;
        mem.raddr = idx_r;
      end
      ST_CMP: begin
        case (op_r)
          REQ_LOOKUP: begin
            if (cmp_lt) begin
              prev_nxt = rpage;
              idx_nxt  = ADDR_W'(idx_r + 1'b1);
              if (at_last && !is_leaf) begin
                resp_hit_nxt  = 1'b1;
                resp_page_nxt = rpage;
              end
            end else if (cmp_eq) begin
              resp_hit_nxt  = 1'b1;
              resp_page_nxt = rpage;
            end else if (!is_leaf) begin
              resp_hit_nxt  = 1'b1;
              resp_page_nxt = (idx_r == '0) ? rpage : prev_r;
            end
          end
          REQ_INSERT: begin
            mem.we    = 1'b1;
            mem.waddr = ADDR_W'(idx_r + 1'b1);
            if (cmp_lt) begin
              mem.wkey     = key_r;
              mem.wpage    = pg_r;
              cnt_nxt      = OCC_W'(cnt_r + 1'b1);
              resp_hit_nxt = 1'b1;
            end else begin
              mem.wkey  = rkey;
              mem.wpage = rpage;
              if (idx_r != '0) begin
                idx_nxt = ADDR_W'(idx_r - 1'b1);
              end
            end
          end
          REQ_REMOVE: begin
            if (cmp_lt) begin
              idx_nxt = ADDR_W'(idx_r + 1'b1);
            end else if (cmp_eq && at_last) begin
              cnt_nxt      = OCC_W'(cnt_r - 1'b1);
              resp_hit_nxt = 1'b1;
            end
          end
          default: begin
            if (cmp_lt) begin
              idx_nxt = ADDR_W'(idx_r + 1'b1);
            end
          end
        endcase
      end
      ST_RCMP: begin
        if (!le) begin
          resp_hit_nxt  = pend_r;
          resp_page_nxt = pend_r ? pend_page_r : '0;
        end else if (!pend_r || out_free) begin
          emit          = pend_r;
          emit_hit      = 1'b1;
          emit_page     = pend_page_r;
          pend_nxt      = 1'b1;
          pend_page_nxt = rpage;
          idx_nxt       = ADDR_W'(idx_r + 1'b1);
          resp_hit_nxt  = 1'b1;
          resp_page_nxt = rpage;
        end
      end
      ST_SH_RD: begin
        mem.re    = 1'b1;
        mem.raddr = ADDR_W'(idx_r + 1'b1);
      end
      ST_SH_WR: begin
        mem.we    = 1'b1;
        mem.waddr = idx_r;
        mem.wkey  = rkey;
        mem.wpage = rpage;
        idx_nxt   = ADDR_W'(idx_r + 1'b1);
        if (ADDR_W'(idx_r + 1'b1) == last_idx) begin
          cnt_nxt      = OCC_W'(cnt_r - 1'b1);
          resp_hit_nxt = 1'b1;
        end
      end
      ST_PUT: begin
        mem.we       = 1'b1;
        mem.waddr    = idx_r;
        mem.wkey     = key_r;
        mem.wpage    = pg_r;
        cnt_nxt      = OCC_W'(cnt_r + 1'b1);
        resp_hit_nxt = 1'b1;
      end
      ST_RESP: begin
        emit      = out_free;
        emit_hit  = resp_hit_r;
        emit_page = resp_page_r;
        emit_last = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    khi_r       <= khi_nxt;
    pg_r        <= pg_nxt;
    idx_r       <= idx_nxt;
    prev_r      <= prev_nxt;
    pend_page_r <= pend_page_nxt;
    resp_hit_r  <= resp_hit_nxt;
    resp_page_r <= resp_page_nxt;
    if (emit) begin
      out_hit_r  <= emit_hit;
      out_page_r <= emit_page;
      out_last_r <= emit_last;
      out_occ_r  <= cnt_r;
    end
  end

endmodule

// File: rtl/sorted_key_page_table_core.sv
// ----------------------------------------------------------------------------
// sorted_key_page_table_core
// one index page as a key-sorted table of key and page number pairs
// ----------------------------------------------------------------------------
// in_ch takes one request transaction (lookup, insert, remove or range) and
// is ready only while no request is in progress. out_ch returns the result
// transactions: one for lookup, insert and remove, one per matching entry
// for a range (last marks the final one), and one miss when nothing matches.
// cfg_ch writes the leaf flag and is always ready; write it only when idle.
// Each scanned entry takes a memory read and then a compare in the shared
// key comparator, and each moved entry a read and then a write. A range
// emits its results one at a time as it scans, and a new request is taken
// only after the final result of the last one is in the output register.
// The entry memory's single read port and the single comparator set this pace.
// A result waits in the output register while out_ch.ready is low; the
// sequencer stalls on the next result until it is taken.
// Reset empties the page and sets the leaf flag; entry memory needs no
// clearing since only slots below the entry count are ever read.
// ----------------------------------------------------------------------------
module sorted_key_page_table_core import skpt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  skpt_req_if.sink     in_ch,
  skpt_rsp_if.source   out_ch,
  skpt_cfg_if.sink     cfg_ch
);

  logic      is_leaf_r;
  mem_ctrl_t mem;
  key_t      rkey;
  page_t     rpage;
  key_t      cmp_b;
  logic      cmp_lt;
  logic      cmp_eq;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_leaf_r <= 1'b1;
    end else if (cfg_ch.valid) begin
      is_leaf_r <= cfg_ch.data;
    end
  end

  skpt_store u_store (
    .clk   (clk),
    .ctrl  (mem),
    .rkey  (rkey),
    .rpage (rpage)
  );

  skpt_cmp u_cmp (
    .a  (rkey),
    .b  (cmp_b),
    .lt (cmp_lt),
    .eq (cmp_eq)
  );

  skpt_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .is_leaf (is_leaf_r),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .mem     (mem),
    .rkey    (rkey),
    .rpage   (rpage),
    .cmp_b   (cmp_b),
    .cmp_lt  (cmp_lt),
    .cmp_eq  (cmp_eq)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request accepted while previous one in progress");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.occupancy <= OCC_W'(CAPACITY)))
    else $error("occupancy above capacity");

  a_miss_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.hit) |-> (out_ch.result_page == '0))
    else $error("miss with non-zero page");

  a_partial_is_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.last) |-> out_ch.hit)
    else $error("non-final range result without hit");
`endif

endmodule

// File: verif/tb_sorted_key_page_table_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_key_page_table_core
// self-checking bench for the sorted key page table core
// ----------------------------------------------------------------------------
// A directed run covers the empty page, extreme keys and page numbers,
// duplicate keys, reversed and empty ranges, and routing on an internal page.
// Random phases then alternate leaf and internal pages under several idling
// patterns, filling the page to capacity and draining it again. A scoreboard
// keeps its own copy of the page and predicts every result transaction.
// ----------------------------------------------------------------------------
module tb_sorted_key_page_table_core;
  import skpt_pkg::*;

  localparam int DRAIN_CYCLES    = 2 * CAPACITY + 8;
  localparam int STALL_LIMIT     = 4000;
  localparam int HOLD_CYCLES     = 300;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 40;
  localparam int MAX_REPORTS     = 20;

  typedef struct {
    logic  hit;
    page_t page;
    logic  last;
    occ_t  occ;
  } page_result_t;

  class page_table_scoreboard;
    key_t         keys[CAPACITY];
    page_t        pages[CAPACITY];
    int           count;
    bit           leaf;
    page_result_t pending_results[$];
    int           errors;
    int           requests;
    int           results;
    int           full_refusals;

    function new();
      count         = 0;
      leaf          = 1'b1;
      errors        = 0;
      requests      = 0;
      results       = 0;
      full_refusals = 0;
    endfunction

    function void push_result(logic hit, page_t pg, logic last);
      page_result_t r;
      r.hit  = hit;
      r.page = pg;
      r.last = last;
      r.occ  = occ_t'(count);
      pending_results.insert(pending_results.size(), r);
    endfunction

    function void note_request(req_t rt, key_t k, key_t kh, page_t pg);
      int           pos;
      int           i;
      int           emitted;
      page_result_t r;
      pos = 0;
      while (pos < count && keys[pos] < k) pos++;
      requests++;
      case (rt)
        REQ_LOOKUP: begin
          if (pos < count && keys[pos] == k) push_result(1'b1, pages[pos], 1'b1);
          else if (leaf || count == 0) push_result(1'b0, '0, 1'b1);
          else if (pos == 0) push_result(1'b1, pages[0], 1'b1);
          else push_result(1'b1, pages[pos-1], 1'b1);
        end
        REQ_INSERT: begin
          if (count >= CAPACITY) begin
            full_refusals++;
            push_result(1'b0, '0, 1'b1);
          end else begin
            for (i = count; i > pos; i--) begin
              keys[i]  = keys[i-1];
              pages[i] = pages[i-1];
            end
            keys[pos]  = k;
            pages[pos] = pg;
            count++;
            push_result(1'b1, '0, 1'b1);
          end
        end
        REQ_REMOVE: begin
          if (pos < count && keys[pos] == k) begin
            for (i = pos; i + 1 < count; i++) begin
              keys[i]  = keys[i+1];
              pages[i] = pages[i+1];
            end
            count--;
            push_result(1'b1, '0, 1'b1);
          end else begin
            push_result(1'b0, '0, 1'b1);
          end
        end
        default: begin
          emitted = 0;
          if (leaf) begin
            for (i = pos; i < count && keys[i] <= kh; i++) begin
              push_result(1'b1, pages[i], 1'b0);
              emitted++;
            end
          end
          if (emitted == 0) begin
            push_result(1'b0, '0, 1'b1);
          end else begin
            r      = pending_results[pending_results.size() - 1];
            r.last = 1'b1;
            pending_results[pending_results.size() - 1] = r;
          end
        end
      endcase
    endfunction

    function void check_result(logic hit, page_t pg, logic last, occ_t occ);
      page_result_t e;
      results++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result: hit %0b page %h last %0b occupancy %0d",
                   $time, hit, pg, last, occ);
        return;
      end
      e = pending_results.pop_front();
      if (e.hit !== hit || e.page !== pg || e.last !== last || e.occ !== occ) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: mismatch: expected hit %0b page %h last %0b occupancy %0d, %s",
                   $time, e.hit, e.page, e.last, e.occ,
                   $sformatf("actual hit %0b page %h last %0b occupancy %0d",
                             hit, pg, last, occ));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  skpt_req_if in_if ();
  skpt_rsp_if out_if ();
  skpt_cfg_if cfg_if ();

  sorted_key_page_table_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  page_table_scoreboard sb;
  key_t key_pool[32];
  int   gap_pct;
  int   stall_pct;
  int   hold_left;
  int   idle_cycles;

  always #6 clk = ~clk;

  // receiver: random stalls, plus a long hold-off when asked
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else begin
        out_if.ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready)
        sb.check_result(out_if.hit, out_if.result_page, out_if.last, out_if.occupancy);
      if (in_if.valid && in_if.ready)
        sb.note_request(req_t'(in_if.req_type), in_if.key, in_if.key_high,
                        in_if.page_number);
      if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic key_t pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 15) return {$urandom, $urandom};
    if (r < 55 && sb.count > 0) return sb.keys[$urandom_range(sb.count - 1)];
    return key_pool[$urandom_range(31)];
  endfunction

  task automatic send_request(input req_t rt, input key_t k, input key_t kh,
                              input page_t pg);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid       = 1'b1;
    in_if.req_type    = rt;
    in_if.key         = k;
    in_if.key_high    = kh;
    in_if.page_number = pg;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // wait until every result transaction is in and the core has gone idle
  task automatic settle();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (sb.pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_leaf(input logic v);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.data  = v;
    do @(posedge clk); while (!cfg_if.ready);
    sb.leaf = v;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  initial begin
    int   p;
    int   r;
    int   r2;
    int   ins_pct;
    int   rem_pct;
    req_t rt;
    key_t k;
    key_t kh;

    sb                = new();
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.req_type    = REQ_LOOKUP;
    in_if.key         = '0;
    in_if.key_high    = '0;
    in_if.page_number = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.data       = 1'b0;
    gap_pct           = 0;
    stall_pct         = 0;
    hold_left         = 0;
    idle_cycles       = 0;
    key_pool[0]       = '0;
    key_pool[1]       = '1;
    for (int i = 2; i < 32; i++) key_pool[i] = {$urandom, $urandom};

    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // leaf page straight out of reset
    send_request(REQ_LOOKUP, 64'd9, '0, '0);
    send_request(REQ_RANGE,  '0, '1, '0);
    send_request(REQ_REMOVE, 64'd9, '0, '0);
    send_request(REQ_INSERT, '0, '0, '0);
    send_request(REQ_INSERT, '1, '0, '1);
    send_request(REQ_INSERT, 64'd5, '1, 32'h1111_0000);
    send_request(REQ_INSERT, 64'd5, '0, 32'h2222_0000);
    send_request(REQ_LOOKUP, 64'd5, '0, '0);
    send_request(REQ_LOOKUP, '1, '0, '0);
    send_request(REQ_LOOKUP, 64'd3, '0, '0);
    send_request(REQ_RANGE,  '0, '1, '0);
    send_request(REQ_RANGE,  64'd6, 64'd2, '0);
    send_request(REQ_RANGE,  64'd5, 64'd5, '0);
    send_request(REQ_RANGE,  64'd1, 64'd4, '0);
    send_request(REQ_REMOVE, 64'd5, '0, '0);
    send_request(REQ_REMOVE, 64'd7, '0, '0);
    settle();

    // internal page routing down to an empty page
    write_leaf(1'b0);
    send_request(REQ_LOOKUP, 64'd3, '0, '0);
    send_request(REQ_LOOKUP, 64'd100, '0, '0);
    send_request(REQ_LOOKUP, '1, '0, '0);
    send_request(REQ_RANGE,  '0, '1, '0);
    send_request(REQ_REMOVE, '0, '0, '0);
    send_request(REQ_LOOKUP, 64'd1, '0, '0);
    send_request(REQ_REMOVE, 64'd5, '0, '0);
    send_request(REQ_REMOVE, '1, '0, '0);
    send_request(REQ_LOOKUP, 64'd7, '0, '0);

    for (p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      write_leaf(p % 2 == 0);
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 50; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 50; end
        default: begin gap_pct = 15; stall_pct = 15; end
      endcase
      if (p == 1) hold_left = HOLD_CYCLES;
      // fill the page in the first half, drain it in the second
      ins_pct = (p < RANDOM_PHASES / 2) ? 55 : 20;
      rem_pct = (p < RANDOM_PHASES / 2) ? 10 : 45;
      repeat (ITEMS_PER_PHASE) begin
        r  = $urandom_range(99);
        k  = pick_key();
        kh = {$urandom, $urandom};
        if (r < ins_pct) begin
          rt = REQ_INSERT;
        end else if (r < ins_pct + rem_pct) begin
          rt = REQ_REMOVE;
        end else if (r < ins_pct + rem_pct + 25) begin
          rt = REQ_LOOKUP;
        end else begin
          rt = REQ_RANGE;
          r2 = $urandom_range(99);
          if (r2 < 45) kh = pick_key();
          else if (r2 < 80) kh = k + $urandom_range(3);
        end
        send_request(rt, k, kh, $urandom);
      end
    end
    settle();

    $display("requests: %0d, result transactions checked: %0d, inserts refused when full: %0d",
             sb.requests, sb.results, sb.full_refusals);
    $display("%0d random phases on leaf and internal pages, one %0d-cycle receiver hold-off",
             RANDOM_PHASES, HOLD_CYCLES);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
